// ===== rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // host commands
    typedef enum logic [2:0] {
        CMD_BEGIN   = 3'd0,
        CMD_WBYTE   = 3'd1,
        CMD_DONE    = 3'd2,
        CMD_STOPREL = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    // bus actions requested from the byte engine
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_START     = 3'd1,
        ACT_RSTART    = 3'd2,
        ACT_SEND      = 3'd3,
        ACT_READ_ACK  = 3'd4,
        ACT_READ_NACK = 3'd5,
        ACT_STOP      = 3'd6,
        ACT_NEED_BYTE = 3'd7
    } action_t;

    // final transaction status
    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_TIMEOUT  = 4'd1,
        ST_ARB      = 4'd2,
        ST_BUS      = 4'd3,
        ST_START    = 4'd4,
        ST_STOPF    = 4'd5,
        ST_ANACK    = 4'd6,
        ST_DNACK    = 4'd7,
        ST_RXF      = 4'd8,
        ST_BADADDR  = 4'd9,
        ST_BADARG   = 4'd10
    } status_t;

    // transfer modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_WR_RD  = 2'd2;
    localparam logic [1:0] MODE_BAD    = 2'd3;

    // engine status codes, already masked
    localparam logic [7:0] ENG_MASK     = 8'hF8;
    localparam logic [7:0] ENG_BUS_ERR  = 8'h00;
    localparam logic [7:0] ENG_START    = 8'h08;
    localparam logic [7:0] ENG_RSTART   = 8'h10;
    localparam logic [7:0] ENG_AW_ACK   = 8'h18;
    localparam logic [7:0] ENG_AW_NACK  = 8'h20;
    localparam logic [7:0] ENG_DW_ACK   = 8'h28;
    localparam logic [7:0] ENG_DW_NACK  = 8'h30;
    localparam logic [7:0] ENG_ARB      = 8'h38;
    localparam logic [7:0] ENG_AR_ACK   = 8'h40;
    localparam logic [7:0] ENG_AR_NACK  = 8'h48;
    localparam logic [7:0] ENG_DR_ACK   = 8'h50;
    localparam logic [7:0] ENG_DR_NACK  = 8'h58;

    // legal seven-bit address window
    localparam logic [6:0] ADDR_LOW  = 7'h08;
    localparam logic [6:0] ADDR_HIGH = 7'h77;

    localparam logic [15:0] POLL_LIMIT_RESET = 16'd50000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  mode;
        logic [6:0]  target_address;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  write_byte;
        logic [7:0]  engine_status;
        logic [7:0]  received_byte;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  bus_byte;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        done_res;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_transaction_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top
// Sequences one I2C master transaction over a byte-level bus engine.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one request per event (begin, write byte, engine done,
//   stop released, tick). Every accepted request gives exactly one result
//   on the m_* channel (action none when the request is out of place).
//   cfg_* channel: writes the poll limit; always ready, write only while
//   no transaction is running.
// Timing:
//   a request is captured in an input register, decided once the result
//   register is free or draining, and then lands in the result register.
//   One request per cycle is sustained while m_ready stays high; the limit
//   is the single decision pass on the registered transaction state.
// Stalls:
//   when m_ready is low the result holds, one more request is still taken
//   into the input register, then s_ready drops until the result drains.
// Reset:
//   aresetn (synchronous, active low) empties both registers, returns the
//   sequencer to idle and loads the poll limit with 50000.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transaction_sequencer_top #(
    parameter int COUNT_BITS = 16,
    parameter int POLL_BITS  = 16
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_cmd,
    input  wire  [1:0]  s_mode,
    input  wire  [6:0]  s_target_address,
    input  wire  [15:0] s_write_count,
    input  wire  [15:0] s_read_count,
    input  wire  [7:0]  s_write_byte,
    input  wire  [7:0]  s_engine_status,
    input  wire  [7:0]  s_received_byte,

    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_action,
    output logic [7:0]  m_bus_byte,
    output logic        m_read_valid,
    output logic [7:0]  m_read_data,
    output logic        m_done_res,
    output logic [3:0]  m_status
);
    import i2cms_pkg::*;

    item_t      item_reg;
    logic       in_vld_reg;
    result_t    out_reg;
    logic       out_vld_reg;
    logic [15:0] poll_limit_reg;

    logic       advance;
    result_t    res;

    // request moves forward when the result register is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    i2cms_ctrl #(
        .COUNT_BITS (COUNT_BITS),
        .POLL_BITS  (POLL_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (item_reg),
        .poll_limit (poll_limit_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            poll_limit_reg <= POLL_LIMIT_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                poll_limit_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd            <= s_cmd;
            item_reg.mode           <= s_mode;
            item_reg.target_address <= s_target_address;
            item_reg.write_count    <= s_write_count;
            item_reg.read_count     <= s_read_count;
            item_reg.write_byte     <= s_write_byte;
            item_reg.engine_status  <= s_engine_status;
            item_reg.received_byte  <= s_received_byte;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_action     = out_reg.action;
    assign m_bus_byte   = out_reg.bus_byte;
    assign m_read_valid = out_reg.read_valid;
    assign m_read_data  = out_reg.read_data;
    assign m_done_res   = out_reg.done_res;
    assign m_status     = out_reg.status;

endmodule

`default_nettype wire

// ===== rtl/i2cms_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transaction state machine: decides one result per request and keeps the
// phase, counts and held status.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ctrl #(
    parameter int COUNT_BITS = 16,
    parameter int POLL_BITS  = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     advance,
    input  wire i2cms_pkg::item_t   item,
    input  wire [15:0]              poll_limit,
    output i2cms_pkg::result_t      res
);
    import i2cms_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_ADDR_W = 4'd2,
        PH_NEED   = 4'd3,
        PH_DATA   = 4'd4,
        PH_RSTART = 4'd5,
        PH_ADDR_R = 4'd6,
        PH_READ   = 4'd7,
        PH_STOP   = 4'd8
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [1:0]            mode_reg, mode_next;
    logic [6:0]            addr_reg, addr_next;
    logic [COUNT_BITS-1:0] writes_reg, writes_next;
    logic [COUNT_BITS-1:0] reads_reg, reads_next;
    logic [POLL_BITS-1:0]  poll_reg, poll_next;
    status_t               held_reg, held_next;

    logic [7:0]            est;
    logic [COUNT_BITS-1:0] wcnt;
    logic [COUNT_BITS-1:0] rcnt;
    logic [COUNT_BITS-1:0] reads_dec;
    logic [POLL_BITS-1:0]  poll_inc;
    logic                  reads_many;

    function automatic status_t classify(input logic [7:0] st, input status_t fb);
        status_t r;
        r = fb;
        if (st == ENG_ARB) begin
            r = ST_ARB;
        end else if (st == ENG_BUS_ERR) begin
            r = ST_BUS;
        end
        return r;
    endfunction

    assign est        = item.engine_status & ENG_MASK;
    assign wcnt       = COUNT_BITS'(item.write_count);
    assign rcnt       = COUNT_BITS'(item.read_count);
    assign reads_dec  = reads_reg - COUNT_BITS'(1);
    assign poll_inc   = poll_reg + POLL_BITS'(1);
    assign reads_many = (reads_reg > COUNT_BITS'(1));

    always_comb begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        addr_next   = addr_reg;
        writes_next = writes_reg;
        reads_next  = reads_reg;
        poll_next   = poll_reg;
        held_next   = held_reg;
        res         = '0;

        if (advance) begin
            unique case (item.cmd)
                CMD_BEGIN: begin
                    if (phase_reg == PH_IDLE) begin
                        if (item.target_address < ADDR_LOW ||
                            item.target_address > ADDR_HIGH) begin
                            res.done_res = 1'b1;
                            res.status   = ST_BADADDR;
                        end else if (item.mode == MODE_BAD ||
                                     (item.mode != MODE_WRITE &&
                                      rcnt == '0)) begin
                            res.done_res = 1'b1;
                            res.status   = ST_BADARG;
                        end else begin
                            mode_next   = item.mode;
                            addr_next   = item.target_address;
                            writes_next = (item.mode == MODE_READ) ? '0 : wcnt;
                            reads_next  = (item.mode == MODE_WRITE) ? '0 : rcnt;
                            held_next   = ST_OK;
                            res.action  = ACT_START;
                            phase_next  = PH_START;
                            poll_next   = '0;
                        end
                    end
                end

                CMD_WBYTE: begin
                    if (phase_reg == PH_NEED) begin
                        writes_next  = writes_reg - COUNT_BITS'(1);
                        res.action   = ACT_SEND;
                        res.bus_byte = item.write_byte;
                        phase_next   = PH_DATA;
                        poll_next    = '0;
                    end
                end

                CMD_DONE: begin
                    unique case (phase_reg)
                        PH_START: begin
                            if (est == ENG_START) begin
                                res.action   = ACT_SEND;
                                res.bus_byte = {addr_reg, mode_reg == MODE_READ};
                                phase_next   = (mode_reg == MODE_READ) ? PH_ADDR_R
                                                                       : PH_ADDR_W;
                                poll_next    = '0;
                            end else begin
                                res.done_res = 1'b1;
                                res.status   = classify(est, ST_START);
                                phase_next   = PH_IDLE;
                            end
                        end
                        PH_RSTART: begin
                            if (est == ENG_RSTART) begin
                                res.action   = ACT_SEND;
                                res.bus_byte = {addr_reg, 1'b1};
                                phase_next   = PH_ADDR_R;
                                poll_next    = '0;
                            end else begin
                                res.done_res = 1'b1;
                                res.status   = classify(est, ST_START);
                                phase_next   = PH_IDLE;
                            end
                        end
                        PH_ADDR_W, PH_DATA: begin
                            if ((phase_reg == PH_ADDR_W && est == ENG_AW_ACK) ||
                                (phase_reg == PH_DATA && est == ENG_DW_ACK)) begin
                                poll_next = '0;
                                // more bytes, stop, or turn around for the read
                                if (writes_reg != '0) begin
                                    res.action = ACT_NEED_BYTE;
                                    phase_next = PH_NEED;
                                end else if (mode_reg == MODE_WRITE) begin
                                    held_next  = ST_OK;
                                    res.action = ACT_STOP;
                                    phase_next = PH_STOP;
                                end else begin
                                    res.action = ACT_RSTART;
                                    phase_next = PH_RSTART;
                                end
                            end else if (phase_reg == PH_ADDR_W &&
                                         est == ENG_AW_NACK) begin
                                held_next  = ST_ANACK;
                                res.action = ACT_STOP;
                                phase_next = PH_STOP;
                                poll_next  = '0;
                            end else if (phase_reg == PH_DATA &&
                                         est == ENG_DW_NACK) begin
                                held_next  = ST_DNACK;
                                res.action = ACT_STOP;
                                phase_next = PH_STOP;
                                poll_next  = '0;
                            end else begin
                                res.done_res = 1'b1;
                                res.status   = classify(est, ST_BUS);
                                phase_next   = PH_IDLE;
                            end
                        end
                        PH_ADDR_R: begin
                            if (est == ENG_AR_ACK) begin
                                res.action = reads_many ? ACT_READ_ACK : ACT_READ_NACK;
                                phase_next = PH_READ;
                                poll_next  = '0;
                            end else if (est == ENG_AR_NACK) begin
                                held_next  = ST_ANACK;
                                res.action = ACT_STOP;
                                phase_next = PH_STOP;
                                poll_next  = '0;
                            end else begin
                                res.done_res = 1'b1;
                                res.status   = classify(est, ST_BUS);
                                phase_next   = PH_IDLE;
                            end
                        end
                        PH_READ: begin
                            if (est == (reads_many ? ENG_DR_ACK : ENG_DR_NACK)) begin
                                res.read_valid = 1'b1;
                                res.read_data  = item.received_byte;
                                reads_next     = reads_dec;
                                poll_next      = '0;
                                if (reads_dec == '0) begin
                                    held_next  = ST_OK;
                                    res.action = ACT_STOP;
                                    phase_next = PH_STOP;
                                end else begin
                                    res.action = (reads_dec > COUNT_BITS'(1)) ?
                                                 ACT_READ_ACK : ACT_READ_NACK;
                                    phase_next = PH_READ;
                                end
                            end else if (est == ENG_ARB || est == ENG_BUS_ERR) begin
                                res.done_res = 1'b1;
                                res.status   = classify(est, ST_BUS);
                                phase_next   = PH_IDLE;
                            end else begin
                                held_next  = ST_RXF;
                                res.action = ACT_STOP;
                                phase_next = PH_STOP;
                                poll_next  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                CMD_STOPREL: begin
                    if (phase_reg == PH_STOP) begin
                        res.done_res = 1'b1;
                        res.status   = held_reg;
                        phase_next   = PH_IDLE;
                    end
                end

                CMD_TICK: begin
                    if (phase_reg != PH_IDLE && phase_reg != PH_NEED) begin
                        poll_next = poll_inc;
                        // compare at a common width so any counter size works
                        if (32'(poll_inc) == 32'(poll_limit)) begin
                            res.done_res = 1'b1;
                            res.status   = (phase_reg == PH_STOP) ? ST_STOPF
                                                                  : ST_TIMEOUT;
                            phase_next   = PH_IDLE;
                        end
                    end
                end

                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            mode_reg   <= '0;
            addr_reg   <= '0;
            writes_reg <= '0;
            reads_reg  <= '0;
            poll_reg   <= '0;
            held_reg   <= ST_OK;
        end else begin
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            addr_reg   <= addr_next;
            writes_reg <= writes_next;
            reads_reg  <= reads_next;
            poll_reg   <= poll_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_i2c_master_transaction_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer_top
// Drives write, read and write-then-read transactions with random engine
// status, ticks and stray commands through the sequencer, predicts every
// result cycle-independently and checks each result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer_top;

    import i2cms_pkg::*;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam int         PHASE_ITEMS  = 180;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         ABORT_AFTER  = 40;

    typedef enum logic [3:0] {
        P_IDLE, P_START, P_ADDR_W, P_NEED, P_DATA, P_RSTART, P_ADDR_R, P_READ, P_STOP
    } bus_phase_e;

    class transaction_scoreboard;
        bus_phase_e  phase       = P_IDLE;
        logic [1:0]  xfer_mode   = MODE_WRITE;
        logic [6:0]  slave_addr  = '0;
        logic [15:0] writes_left = '0;
        logic [15:0] reads_left  = '0;
        logic [15:0] polls       = '0;
        logic [15:0] poll_limit  = POLL_LIMIT_RESET;
        status_t     held        = ST_OK;
        bit          ignored;
        int          errors      = 0;
        result_t     outcome;
        result_t     awaited_results[$];

        function void issue(action_t act, logic [7:0] data, bus_phase_e nxt);
            outcome.action   = act;
            outcome.bus_byte = data;
            phase            = nxt;
            polls            = '0;
        endfunction

        function void conclude(status_t st);
            outcome.done_res = 1'b1;
            outcome.status   = st;
            phase            = P_IDLE;
        endfunction

        function void stop_with(status_t st);
            held = st;
            issue(ACT_STOP, 8'h00, P_STOP);
        endfunction

        function status_t classify(logic [7:0] st, status_t fallback);
            if (st == ENG_ARB)
                return ST_ARB;
            if (st == ENG_BUS_ERR)
                return ST_BUS;
            return fallback;
        endfunction

        function void after_write();
            if (writes_left != 0)
                issue(ACT_NEED_BYTE, 8'h00, P_NEED);
            else if (xfer_mode == MODE_WRITE)
                stop_with(ST_OK);
            else
                issue(ACT_RSTART, 8'h00, P_RSTART);
        endfunction

        function void issue_read();
            issue(reads_left > 1 ? ACT_READ_ACK : ACT_READ_NACK, 8'h00, P_READ);
        endfunction

        function void engine_done(logic [7:0] st, logic [7:0] rx);
            bit rd;
            ignored = 1'b0;
            case (phase)
                P_START: begin
                    if (st == ENG_START) begin
                        rd = (xfer_mode == MODE_READ);
                        issue(ACT_SEND, {slave_addr, rd}, rd ? P_ADDR_R : P_ADDR_W);
                    end else begin
                        conclude(classify(st, ST_START));
                    end
                end
                P_RSTART: begin
                    if (st == ENG_RSTART)
                        issue(ACT_SEND, {slave_addr, 1'b1}, P_ADDR_R);
                    else
                        conclude(classify(st, ST_START));
                end
                P_ADDR_W: begin
                    if (st == ENG_AW_ACK)
                        after_write();
                    else if (st == ENG_AW_NACK)
                        stop_with(ST_ANACK);
                    else
                        conclude(classify(st, ST_BUS));
                end
                P_DATA: begin
                    if (st == ENG_DW_ACK)
                        after_write();
                    else if (st == ENG_DW_NACK)
                        stop_with(ST_DNACK);
                    else
                        conclude(classify(st, ST_BUS));
                end
                P_ADDR_R: begin
                    if (st == ENG_AR_ACK)
                        issue_read();
                    else if (st == ENG_AR_NACK)
                        stop_with(ST_ANACK);
                    else
                        conclude(classify(st, ST_BUS));
                end
                P_READ: begin
                    // the last byte is read with nack, so its good status differs
                    if (st == (reads_left > 1 ? ENG_DR_ACK : ENG_DR_NACK)) begin
                        outcome.read_valid = 1'b1;
                        outcome.read_data  = rx;
                        reads_left         = reads_left - 16'd1;
                        if (reads_left == 0)
                            stop_with(ST_OK);
                        else
                            issue_read();
                    end else if (st == ENG_ARB || st == ENG_BUS_ERR) begin
                        conclude(classify(st, ST_BUS));
                    end else begin
                        stop_with(ST_RXF);
                    end
                end
                default: ignored = 1'b1;
            endcase
        endfunction

        function void note_request(item_t r);
            outcome        = '0;
            outcome.action = ACT_NONE;
            outcome.status = ST_OK;
            ignored        = 1'b1;
            case (r.cmd)
                CMD_BEGIN: begin
                    if (phase == P_IDLE) begin
                        ignored = 1'b0;
                        if (r.target_address < ADDR_LOW || r.target_address > ADDR_HIGH) begin
                            conclude(ST_BADADDR);
                        end else if (r.mode == MODE_BAD ||
                                     (r.mode != MODE_WRITE && r.read_count == 0)) begin
                            conclude(ST_BADARG);
                        end else begin
                            xfer_mode   = r.mode;
                            slave_addr  = r.target_address;
                            writes_left = (r.mode == MODE_READ) ? 16'd0 : r.write_count;
                            reads_left  = (r.mode == MODE_WRITE) ? 16'd0 : r.read_count;
                            held        = ST_OK;
                            issue(ACT_START, 8'h00, P_START);
                        end
                    end
                end
                CMD_WBYTE: begin
                    if (phase == P_NEED) begin
                        ignored     = 1'b0;
                        writes_left = writes_left - 16'd1;
                        issue(ACT_SEND, r.write_byte, P_DATA);
                    end
                end
                CMD_DONE: engine_done(r.engine_status & ENG_MASK, r.received_byte);
                CMD_STOPREL: begin
                    if (phase == P_STOP) begin
                        ignored = 1'b0;
                        conclude(held);
                    end
                end
                CMD_TICK: begin
                    if (phase != P_IDLE && phase != P_NEED) begin
                        ignored = 1'b0;
                        polls   = polls + 16'd1;
                        if (polls == poll_limit)
                            conclude(phase == P_STOP ? ST_STOPF : ST_TIMEOUT);
                    end
                end
                default: ;
            endcase
            awaited_results.push_back(outcome);
        endfunction

        function void compare_field(string what, logic [7:0] want, logic [7:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none, actual action %0h",
                         $time, got.action);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("action", 8'(want.action), 8'(got.action));
            compare_field("bus_byte", want.bus_byte, got.bus_byte);
            compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("status", 8'(want.status), 8'(got.status));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_cmd;
    logic [1:0]  s_mode;
    logic [6:0]  s_target_address;
    logic [15:0] s_write_count;
    logic [15:0] s_read_count;
    logic [7:0]  s_write_byte;
    logic [7:0]  s_engine_status;
    logic [7:0]  s_received_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_action;
    logic [7:0]  m_bus_byte;
    logic        m_read_valid;
    logic [7:0]  m_read_data;
    logic        m_done_res;
    logic [3:0]  m_status;

    transaction_scoreboard sb = new();
    bit s_calm;
    int quiet_cycles;

    i2c_master_transaction_sequencer_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_mode           (s_mode),
        .s_target_address (s_target_address),
        .s_write_count    (s_write_count),
        .s_read_count     (s_read_count),
        .s_write_byte     (s_write_byte),
        .s_engine_status  (s_engine_status),
        .s_received_byte  (s_received_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_bus_byte       (m_bus_byte),
        .m_read_valid     (m_read_valid),
        .m_read_data      (m_read_data),
        .m_done_res       (m_done_res),
        .m_status         (m_status)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic item_t req(logic [2:0] c, logic [1:0] m, logic [6:0] a,
                                  logic [15:0] wc, logic [15:0] rc, logic [7:0] wb,
                                  logic [7:0] es, logic [7:0] rx);
        item_t r;
        r.cmd            = c;
        r.mode           = m;
        r.target_address = a;
        r.write_count    = wc;
        r.read_count     = rc;
        r.write_byte     = wb;
        r.engine_status  = es;
        r.received_byte  = rx;
        return r;
    endfunction

    function automatic item_t random_request();
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        w0 = $urandom;
        w1 = $urandom;
        w2 = $urandom;
        return req(w0[2:0], w0[4:3], w0[11:5], w1[15:0], w1[31:16], w0[19:12],
                   w0[27:20], w2[7:0]);
    endfunction

    function automatic logic [7:0] good_status();
        case (sb.phase)
            P_START:  return ENG_START;
            P_RSTART: return ENG_RSTART;
            P_ADDR_W: return ENG_AW_ACK;
            P_DATA:   return ENG_DW_ACK;
            P_ADDR_R: return ENG_AR_ACK;
            default:  return sb.reads_left > 1 ? ENG_DR_ACK : ENG_DR_NACK;
        endcase
    endfunction

    function automatic logic [7:0] bad_status();
        case ($urandom_range(0, 7))
            0:       return ENG_BUS_ERR;
            1:       return ENG_ARB;
            2:       return ENG_AW_NACK;
            3:       return ENG_DW_NACK;
            4:       return ENG_AR_NACK;
            5:       return ENG_DR_ACK;
            6:       return ENG_DR_NACK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly the request the sequencer waits for, with ticks, faults and strays mixed in;
    // wind_down forces the shortest way back to idle
    function automatic item_t next_request(bit stubborn, bit wind_down);
        item_t r;
        int    pick;
        int    tick_pct;
        int    sel;
        r        = random_request();
        pick     = $urandom_range(0, 99);
        tick_pct = stubborn ? 70 : 12;
        case (sb.phase)
            P_IDLE: begin
                if (pick >= 5) begin
                    r.cmd  = CMD_BEGIN;
                    r.mode = ($urandom_range(0, 99) < 4) ? MODE_BAD : 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 19) == 0) begin
                        sel              = $urandom_range(0, 15);
                        r.target_address = (sel < 8) ? 7'(sel) : 7'(sel + 112);
                    end else begin
                        r.target_address = 7'($urandom_range(8, 119));
                    end
                    sel = $urandom_range(0, 99);
                    if (sel < 85)
                        r.write_count = 16'($urandom_range(0, 4));
                    else if (sel < 92)
                        r.write_count = 16'd0;
                    sel = $urandom_range(0, 99);
                    if (sel < 80)
                        r.read_count = 16'($urandom_range(1, 4));
                    else if (sel < 88)
                        r.read_count = 16'd0;
                end
            end
            P_NEED: begin
                if (wind_down || pick >= 12)
                    r.cmd = CMD_WBYTE;
            end
            P_STOP: begin
                if (wind_down || pick >= tick_pct + 4)
                    r.cmd = CMD_STOPREL;
                else if (pick < tick_pct)
                    r.cmd = CMD_TICK;
            end
            default: begin
                if (wind_down) begin
                    r.cmd           = CMD_DONE;
                    r.engine_status = ENG_ARB | 8'($urandom_range(0, 7));
                end else if (pick < tick_pct) begin
                    r.cmd = CMD_TICK;
                end else if (pick < tick_pct + 8) begin
                    r.cmd           = CMD_DONE;
                    r.engine_status = bad_status();
                end else if (pick >= tick_pct + 12) begin
                    // low three bits are masked off by the block
                    r.cmd           = CMD_DONE;
                    r.engine_status = good_status() | 8'($urandom_range(0, 7));
                end
            end
        endcase
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(item_t r);
        int gap;
        if ($urandom_range(0, 39) == 0)
            s_calm = !s_calm;
        gap = s_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd            = r.cmd;
        s_mode           = r.mode;
        s_target_address = r.target_address;
        s_write_count    = r.write_count;
        s_read_count     = r.read_count;
        s_write_byte     = r.write_byte;
        s_engine_status  = r.engine_status;
        s_received_byte  = r.received_byte;
        s_valid          = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic set_poll_limit(logic [15:0] limit);
        cfg_data  = limit;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.poll_limit = limit;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wind_down_and_settle(int pause);
        while (sb.phase != P_IDLE)
            send_request(next_request(1'b0, 1'b1));
        s_valid = 1'b0;
        while (sb.awaited_results.size() != 0)
            @(negedge aclk);
        repeat (pause) @(negedge aclk);
    endtask

    always @(posedge aclk) begin : collect
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.action     = action_t'(m_action);
            got.bus_byte   = m_bus_byte;
            got.read_valid = m_read_valid;
            got.read_data  = m_read_data;
            got.done_res   = m_done_res;
            got.status     = status_t'(m_status);
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("i2c_master_transaction_sequencer_top verification failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : result_side
        int stall;
        bit calm;
        calm    = 1'b0;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : request_side
        logic [15:0] limits [7];
        bit          stubborn;
        int          txn_items;
        int          counted;
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_calm           = 1'b0;
        quiet_cycles     = 0;
        {s_cmd, s_mode, s_target_address, s_write_count, s_read_count} = '0;
        {s_write_byte, s_engine_status, s_received_byte}                = '0;
        stubborn         = 1'b0;
        txn_items        = 0;
        limits           = '{16'd1, 16'd65535, 16'd3, POLL_LIMIT_RESET, 16'd2, 16'd5, 16'd0};
        limits[6]        = 16'($urandom_range(2, 20));
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed requests with a two-tick poll limit
        set_poll_limit(16'd2);
        send_request(req(CMD_BEGIN, MODE_WRITE, 7'h07, 16'd1, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_BEGIN, MODE_READ, 7'h78, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_BEGIN, MODE_BAD, ADDR_LOW, 16'd2, 16'd2, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_BEGIN, MODE_READ, ADDR_HIGH, 16'hFFFF, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_TICK, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_UNUSED, MODE_BAD, 7'h7F, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        // long write then read, cut short by a data nack
        send_request(req(CMD_BEGIN, MODE_WR_RD, ADDR_LOW, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00,
                         8'h00));
        send_request(req(CMD_BEGIN, MODE_WRITE, 7'h30, 16'd1, 16'd1, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_START | 8'h07,
                         8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_AW_ACK, 8'h00));
        send_request(req(CMD_TICK, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_WBYTE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'hFF, 8'h00, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_DW_NACK, 8'h00));
        send_request(req(CMD_STOPREL, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        // two-byte read at the top address
        send_request(req(CMD_BEGIN, MODE_READ, ADDR_HIGH, 16'd0, 16'd2, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_START, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_AR_ACK, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_DR_ACK, 8'hFF));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_DR_NACK, 8'h00));
        send_request(req(CMD_STOPREL, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        // engine never answers
        send_request(req(CMD_BEGIN, MODE_WRITE, 7'h50, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_TICK, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_TICK, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        // arbitration lost on the repeated start
        send_request(req(CMD_BEGIN, MODE_WR_RD, 7'h2A, 16'd0, 16'd1, 8'h00, 8'h00, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_START, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_AW_ACK, 8'h00));
        send_request(req(CMD_DONE, MODE_WRITE, 7'h00, 16'd0, 16'd0, 8'h00, ENG_ARB, 8'h00));
        wind_down_and_settle(4);

        foreach (limits[i]) begin
            set_poll_limit(limits[i]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (sb.phase == P_IDLE) begin
                    stubborn  = ($urandom_range(0, 9) == 0);
                    txn_items = 0;
                end
                send_request(next_request(stubborn, txn_items > ABORT_AFTER));
                txn_items++;
                if (!sb.ignored)
                    counted++;
            end
            wind_down_and_settle(4);
        end

        repeat (8) @(negedge aclk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("i2c_master_transaction_sequencer_top verification clean");
        else
            $display("i2c_master_transaction_sequencer_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2cms_pkg.sv
rtl/i2cms_ctrl.sv
rtl/i2c_master_transaction_sequencer_top.sv
tb/tb_i2c_master_transaction_sequencer_top.sv
